@@ rtl/core/m3i_pkg.sv @@
// Shared constants, tables and types for the 3x3 matrix inverse pipeline.
`default_nettype none

package m3i_pkg;

  // Matrix format
  localparam int FRAC_BITS_DEF = 16;
  localparam int ELEM_W        = 32;
  localparam int N_ELEM        = 9;
  localparam int TDATA_W       = ELEM_W * N_ELEM;
  localparam int TUSER_W       = 2;
  localparam int THR_W         = 31;

  // Determinant width: 32x64 signed products summed three times, plus margin
  localparam int DET_W = 98;
  // Quotient bits kept by the divider; larger quotients saturate anyway
  localparam int QBITS = 33;

  // tuser bit positions
  localparam int USER_SINGULAR = 0;
  localparam int USER_OVERFLOW = 1;

  // Saturation limits
  localparam logic [ELEM_W-1:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [ELEM_W-1:0] MIN_NEG = 32'h8000_0000;

  // Cofactor k = e[op0]*e[op1] - e[op2]*e[op3], elements in row-major order
  localparam int unsigned CF_OP [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

  // Output element k takes the transposed cofactor
  localparam int unsigned OUT_CF [N_ELEM] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};

  // Per-item data carried alongside the divider lanes
  typedef struct packed {
    logic [TDATA_W-1:0] mat;
    logic               sing;
    logic [N_ELEM-1:0]  big;
    logic [N_ELEM-1:0]  neg;
  } side_t;

endpackage

`default_nettype wire

@@ rtl/core/matrix3x3_inverse.sv @@
// Top level: pipelined 3x3 fixed-point matrix inverse by adjugate and division.
//
// Channel | Direction | Handshake            | Payload
// s       | in        | s_tvalid / s_tready  | s_tdata: a00..a22, 32 bits each, a00 lowest
// m       | out       | m_tvalid / m_tready  | m_tdata: r00..r22; m_tuser: singular, overflow
// cfg     | in        | cfg_valid / cfg_ready| cfg_data: singular_threshold (31 bits)
//
// One matrix enters per cycle while the output register is not stalled; the latency is
// set by the 33 bit-per-stage quotient stages of the nine divider lanes.
// Reset clears the valid bits and loads the threshold with 1.
// The whole pipeline holds while a result waits in the output register; nothing is lost.
`default_nettype none

module matrix3x3_inverse #(
  parameter int FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [m3i_pkg::TDATA_W-1:0]   s_tdata,   // a00,a01,a02,a10,..,a22 from bit 0
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [m3i_pkg::TDATA_W-1:0]   m_tdata,   // r00,r01,r02,r10,..,r22 from bit 0
  output logic      [m3i_pkg::TUSER_W-1:0]   m_tuser,   // singular, overflow from bit 0
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [m3i_pkg::THR_W-1:0]     cfg_data
);

  localparam int EW      = m3i_pkg::ELEM_W;
  localparam int NE      = m3i_pkg::N_ELEM;
  localparam int TW      = m3i_pkg::TDATA_W;
  localparam int DW      = m3i_pkg::DET_W;
  localparam int QW      = m3i_pkg::QBITS;
  localparam int NW      = 64 + 2 * FRAC_BITS;
  localparam int CW      = DW + QW;
  localparam int DIV_LAT = QW + 1;
  localparam int PIPE    = 7 + DIV_LAT;

  logic adv;
  logic [PIPE-1:0] vld;
  logic [m3i_pkg::THR_W-1:0] thr;

  assign adv       = !m_tvalid || m_tready;
  assign s_tready  = adv;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= m3i_pkg::THR_W'(1);
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  // Valid bits and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[PIPE-2:0], s_tvalid};
      m_tvalid <= vld[PIPE-1];
    end
  end

  // Stage 1: cofactor products
  logic [TW-1:0]      mat1;
  logic signed [63:0] pa1 [NE];
  logic signed [63:0] pb1 [NE];
  logic signed [EW-1:0] ein [NE];

  for (genvar k = 0; k < NE; k++) begin : g_ein
    assign ein[k] = $signed(s_tdata[EW*k +: EW]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat1 <= s_tdata;
      for (int k = 0; k < NE; k++) begin
        pa1[k] <= ein[m3i_pkg::CF_OP[k][0]] * ein[m3i_pkg::CF_OP[k][1]];
        pb1[k] <= ein[m3i_pkg::CF_OP[k][2]] * ein[m3i_pkg::CF_OP[k][3]];
      end
    end
  end

  // Stage 2: cofactors
  logic [TW-1:0]      mat2;
  logic signed [63:0] cf2 [NE];

  always_ff @(posedge clk) begin
    if (adv) begin
      mat2 <= mat1;
      for (int k = 0; k < NE; k++) begin
        cf2[k] <= pa1[k] - pb1[k];
      end
    end
  end

  // Stage 3: row-0 expansion, 32x64 split into two 32x32 partial products
  logic [TW-1:0]      mat3;
  logic signed [63:0] cf3 [NE];
  logic signed [64:0] lo3 [3];
  logic signed [63:0] hi3 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mat3 <= mat2;
      for (int k = 0; k < NE; k++) begin
        cf3[k] <= cf2[k];
      end
      for (int k = 0; k < 3; k++) begin
        lo3[k] <= $signed(mat2[EW*k +: EW]) * $signed({1'b0, cf2[k][31:0]});
        hi3[k] <= $signed(mat2[EW*k +: EW]) * $signed(cf2[k][63:32]);
      end
    end
  end

  // Stage 4: recombine partials
  logic [TW-1:0]        mat4;
  logic signed [63:0]   cf4 [NE];
  logic signed [DW-1:0] pr4 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      mat4 <= mat3;
      for (int k = 0; k < NE; k++) begin
        cf4[k] <= cf3[k];
      end
      for (int k = 0; k < 3; k++) begin
        pr4[k] <= (DW'(hi3[k]) <<< 32) + DW'(lo3[k]);
      end
    end
  end

  // Stage 5: determinant
  logic [TW-1:0]        mat5;
  logic signed [63:0]   cf5 [NE];
  logic signed [DW-1:0] det5;

  always_ff @(posedge clk) begin
    if (adv) begin
      mat5 <= mat4;
      for (int k = 0; k < NE; k++) begin
        cf5[k] <= cf4[k];
      end
      det5 <= pr4[0] + pr4[1] + pr4[2];
    end
  end

  // Stage 6: magnitudes and signs
  logic [TW-1:0]   mat6;
  logic [DW-1:0]   dmag6;
  logic            dneg6;
  logic [63:0]     cmag6 [NE];
  logic [NE-1:0]   cneg6;

  always_ff @(posedge clk) begin
    if (adv) begin
      mat6  <= mat5;
      dneg6 <= det5[DW-1];
      dmag6 <= det5[DW-1] ? DW'(-det5) : DW'(det5);
      for (int k = 0; k < NE; k++) begin
        cneg6[k] <= cf5[k][63];
        cmag6[k] <= cf5[k][63] ? 64'(-cf5[k]) : 64'(cf5[k]);
      end
    end
  end

  // Stage 7: singular test, numerators, early saturation test
  m3i_pkg::side_t side7;
  logic [DW-1:0]  dmag7;
  logic [NW-1:0]  num7 [NE];

  always_ff @(posedge clk) begin
    if (adv) begin
      side7.mat  <= mat6;
      side7.sing <= (dmag6 == '0) || (dmag6 < (DW'(thr) << (2 * FRAC_BITS)));
      dmag7      <= dmag6;
      for (int k = 0; k < NE; k++) begin
        num7[k]       <= NW'(cmag6[m3i_pkg::OUT_CF[k]]) << (2 * FRAC_BITS);
        side7.big[k]  <= (CW'(cmag6[m3i_pkg::OUT_CF[k]]) << (2 * FRAC_BITS))
                         >= (CW'(dmag6) << QW);
        side7.neg[k]  <= cneg6[m3i_pkg::OUT_CF[k]] ^ dneg6;
      end
    end
  end

  // Divider lanes
  logic [QW-1:0] quo [NE];
  logic [NE-1:0] rup;

  for (genvar k = 0; k < NE; k++) begin : g_lane
    m3i_div #(.NUM_W(NW)) u_div (
      .clk (clk),
      .adv (adv),
      .num (num7[k]),
      .den (dmag7),
      .quo (quo[k]),
      .up  (rup[k])
    );
  end

  // Side data delay matching the lanes
  m3i_pkg::side_t sd [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side7;
      for (int j = 1; j < DIV_LAT; j++) begin
        sd[j] <= sd[j-1];
      end
    end
  end

  // Final rounding, saturation and pass-through select
  m3i_pkg::side_t      sf;
  logic [TW-1:0]       res;
  logic [NE-1:0]       sat;
  logic [QW:0]         qr [NE];

  assign sf = sd[DIV_LAT-1];

  always_comb begin
    res = '0;
    sat = '0;
    for (int k = 0; k < NE; k++) begin
      qr[k] = (QW+1)'(quo[k]) + (QW+1)'(rup[k]);
      if (!sf.neg[k]) begin
        sat[k] = sf.big[k] || (qr[k] > (QW+1)'(m3i_pkg::MAX_POS));
        res[EW*k +: EW] = sat[k] ? m3i_pkg::MAX_POS : qr[k][EW-1:0];
      end else begin
        sat[k] = sf.big[k] || (qr[k] > (QW+1)'(m3i_pkg::MIN_NEG));
        res[EW*k +: EW] = sat[k] ? m3i_pkg::MIN_NEG : EW'(-qr[k][EW-1:0]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata                         <= sf.sing ? sf.mat : res;
      m_tuser[m3i_pkg::USER_SINGULAR] <= sf.sing;
      m_tuser[m3i_pkg::USER_OVERFLOW] <= !sf.sing && (|sat);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/m3i_div.sv @@
// One divider lane: pipelined restoring division, one quotient bit per stage, then rounding.
`default_nettype none

module m3i_div #(
  parameter int NUM_W = 64 + 2 * m3i_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic [NUM_W-1:0]              num,
  input  wire logic [m3i_pkg::DET_W-1:0]     den,
  output logic      [m3i_pkg::QBITS-1:0]     quo,
  output logic                               up
);

  localparam int DW = m3i_pkg::DET_W;
  localparam int QW = m3i_pkg::QBITS;

  logic [DW-1:0] rem [QW];
  logic [QW-1:0] low [QW];
  logic [QW-1:0] qt  [QW];
  logic [DW-1:0] dd  [QW];

  // One compare-subtract per stage
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] rin;
    logic [DW-1:0] dn;
    logic [QW-1:0] lin;
    logic [QW-1:0] qin;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (j == 0) begin : g_first
      assign rin = DW'(num[NUM_W-1:QW]);
      assign lin = num[QW-1:0];
      assign qin = '0;
      assign dn  = den;
    end else begin : g_next
      assign rin = rem[j-1];
      assign lin = low[j-1];
      assign qin = qt[j-1];
      assign dn  = dd[j-1];
    end

    assign trial = {rin, lin[QW-1]};
    assign diff  = trial - {1'b0, dn};
    assign ge    = trial >= {1'b0, dn};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[j] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        low[j] <= {lin[QW-2:0], 1'b0};
        qt[j]  <= {qin[QW-2:0], ge};
        dd[j]  <= dn;
      end
    end
  end

  // Round to nearest, ties away from zero
  always_ff @(posedge clk) begin
    if (adv) begin
      quo <= qt[QW-1];
      up  <= {rem[QW-1], 1'b0} >= {1'b0, dd[QW-1]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/m3i_chk.sv @@
// Port-level checker for the matrix inverse, bound to the top level.
`default_nettype none

module m3i_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [m3i_pkg::TDATA_W-1:0]   m_tdata,
  input wire logic [m3i_pkg::TUSER_W-1:0]   m_tuser
);

  // A stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Singular results never report saturation
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[m3i_pkg::USER_SINGULAR] && m_tuser[m3i_pkg::USER_OVERFLOW]))
    else $error("singular and overflow both set");

  // Input is taken whenever the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output stall");

endmodule

bind matrix3x3_inverse m3i_chk u_chk (.*);

`default_nettype wire

@@ verif/matrix3x3_inverse_checker.sv @@
// Checker for the 3x3 matrix inverse: predicts each result and compares it field by field.
module matrix3x3_inverse_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [m3i_pkg::TDATA_W-1:0] s_tdata,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [m3i_pkg::TDATA_W-1:0] m_tdata,
  input  logic [m3i_pkg::TUSER_W-1:0] m_tuser,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [m3i_pkg::THR_W-1:0]   cfg_data,
  output int                          fail_count,
  output int                          pending
);

  localparam int FB = m3i_pkg::FRAC_BITS_DEF;
  localparam int EW = m3i_pkg::ELEM_W;

  typedef struct {
    logic [m3i_pkg::TDATA_W-1:0] elems;
    logic                        sing;
    logic                        ovf;
  } inv_result_t;

  inv_result_t inverse_q[$];
  logic [m3i_pkg::THR_W-1:0] threshold;

  assign pending = inverse_q.size();

  // Exact adjugate / determinant prediction with rounded, saturated quotients
  function automatic inv_result_t predict_inverse(logic [m3i_pkg::TDATA_W-1:0] mat,
                                                  logic [m3i_pkg::THR_W-1:0] thr);
    inv_result_t res;
    logic signed [63:0]  e[9];
    logic signed [63:0]  cof[9];
    logic signed [127:0] det;
    logic [127:0]        dmag, num, quo, rmd, lim;
    logic signed [63:0]  c;
    logic                neg;
    for (int k = 0; k < 9; k++) e[k] = 64'(signed'(mat[k*EW +: EW]));
    cof[0] = e[4]*e[8] - e[5]*e[7];
    cof[1] = e[5]*e[6] - e[3]*e[8];
    cof[2] = e[3]*e[7] - e[4]*e[6];
    cof[3] = e[2]*e[7] - e[1]*e[8];
    cof[4] = e[0]*e[8] - e[2]*e[6];
    cof[5] = e[1]*e[6] - e[0]*e[7];
    cof[6] = e[1]*e[5] - e[2]*e[4];
    cof[7] = e[2]*e[3] - e[0]*e[5];
    cof[8] = e[0]*e[4] - e[1]*e[3];
    det = 128'(e[0])*128'(cof[0]) + 128'(e[1])*128'(cof[1]) + 128'(e[2])*128'(cof[2]);
    dmag = det[127] ? -det : det;
    lim = 128'(thr) << (2*FB);
    res.ovf = 1'b0;
    if (dmag == 0 || dmag < lim) begin
      res.elems = mat;
      res.sing = 1'b1;
      return res;
    end
    res.sing = 1'b0;
    for (int k = 0; k < 9; k++) begin
      c = cof[3*(k%3) + k/3];
      neg = c[63] != det[127];
      num = 128'(c[63] ? -c : c) << (2*FB);
      quo = num / dmag;
      rmd = num % dmag;
      if ((rmd << 1) >= dmag) quo = quo + 1;
      if (!neg) begin
        if (quo > 128'h7FFF_FFFF) begin
          res.elems[k*EW +: EW] = m3i_pkg::MAX_POS;
          res.ovf = 1'b1;
        end else res.elems[k*EW +: EW] = quo[31:0];
      end else begin
        if (quo > 128'h8000_0000) begin
          res.elems[k*EW +: EW] = m3i_pkg::MIN_NEG;
          res.ovf = 1'b1;
        end else res.elems[k*EW +: EW] = -quo[31:0];
      end
    end
    return res;
  endfunction

  // Track threshold, queue predictions, compare results
  always @(posedge clk) begin
    inv_result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      threshold <= m3i_pkg::THR_W'(1);
      fail_count <= 0;
      inverse_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (s_tvalid && s_tready) inverse_q.push_back(predict_inverse(s_tdata, threshold));
      if (m_tvalid && m_tready) begin
        if (inverse_q.size() == 0) begin
          $error("unexpected result transaction");
          errs++;
        end else begin
          want = inverse_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (m_tdata[k*EW +: EW] !== want.elems[k*EW +: EW]) begin
              $error("r%0d%0d: expected %h actual %h", k/3, k%3,
                     want.elems[k*EW +: EW], m_tdata[k*EW +: EW]);
              errs++;
            end
          if (m_tuser[m3i_pkg::USER_SINGULAR] !== want.sing) begin
            $error("singular: expected %b actual %b", want.sing,
                   m_tuser[m3i_pkg::USER_SINGULAR]);
            errs++;
          end
          if (m_tuser[m3i_pkg::USER_OVERFLOW] !== want.ovf) begin
            $error("overflow: expected %b actual %b", want.ovf,
                   m_tuser[m3i_pkg::USER_OVERFLOW]);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ verif/matrix3x3_inverse_tb.sv @@
// Testbench top for the 3x3 matrix inverse: stimulus, handshake pressure and verdict.
module matrix3x3_inverse_tb;

  localparam int LATENCY   = 7 + m3i_pkg::QBITS + 2;
  localparam int WATCH_MAX = 4000;
  localparam int N_RANDOM  = 1350;
  localparam int TW        = m3i_pkg::TDATA_W;
  localparam int THW       = m3i_pkg::THR_W;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [TW-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [TW-1:0] m_tdata;
  logic [m3i_pkg::TUSER_W-1:0] m_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [THW-1:0] cfg_data = '0;
  int fail_count, pending;
  logic calm = 0;
  int idle_cycles = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  matrix3x3_inverse i_dut (.*);

  matrix3x3_inverse_checker i_checker (.*);

  // Receiver stalls about 7 percent of the time unless in a calm stretch
  always @(negedge clk) m_tready <= calm || ($urandom_range(99) >= 7);

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  // One matrix transaction, with an optional sender gap first;
  // valid stays high on return so transactions can follow back to back
  task automatic send_matrix(logic [TW-1:0] mat);
    while (!calm && $urandom_range(99) < 7) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= mat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [THW-1:0] thr);
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] fx(int v);
    return 32'(v) << 16;
  endfunction

  function automatic logic [TW-1:0] pack9(logic [31:0] x0, x1, x2, x3, x4, x5,
                                          x6, x7, x8);
    return {x8, x7, x6, x5, x4, x3, x2, x1, x0};
  endfunction

  // Random element: wide spread, small values, or extremes
  function automatic logic [31:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      3: return 32'($signed($urandom_range(0, 512)) - 256);
      default: return 32'($signed($urandom_range(0, 64 << 16)) - (32 << 16));
    endcase
  endfunction

  // Half are well-conditioned (scaled identity plus random perturbation), the rest random, a tenth rank-deficient
  function automatic logic [TW-1:0] rand_matrix();
    logic [TW-1:0] m;
    int sel;
    sel = $urandom_range(9);
    for (int k = 0; k < 9; k++) m[k*32 +: 32] = rand_elem();
    if (sel < 5) begin
      for (int k = 0; k < 9; k++) m[k*32 +: 32] = 32'($signed($urandom_range(0, 1 << 17))
                                                       - (1 << 16));
      for (int k = 0; k < 9; k += 4) m[k*32 +: 32] = m[k*32 +: 32] + fx(2);
    end else if (sel == 5) begin
      // rank-deficient: row 2 copies row 0
      for (int k = 0; k < 3; k++) m[(6+k)*32 +: 32] = m[k*32 +: 32];
    end
    return m;
  endfunction

  task automatic run_random(int n);
    repeat (n) send_matrix(rand_matrix());
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: identity, scaled, singular, extremes, saturation
    send_matrix(pack9(fx(1), 0, 0, 0, fx(1), 0, 0, 0, fx(1)));
    send_matrix(pack9(fx(2), 0, 0, 0, fx(-4), 0, 0, 0, fx(8)));
    send_matrix('0);
    send_matrix(pack9(fx(1), fx(2), fx(3), fx(4), fx(5), fx(6), fx(7), fx(8), fx(9)));
    send_matrix(pack9(fx(2), fx(1), 0, fx(1), fx(3), fx(1), 0, fx(1), fx(4)));
    send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(pack9(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 32'h8000_0000));
    send_matrix(pack9(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));
    send_matrix({9{32'hFFFF_FFFF}});
    send_matrix(pack9(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h8000_0000));
    send_matrix(pack9(256, 0, 0, 0, -256, 0, 0, 0, 256));
    send_matrix(pack9(fx(3), 1, 0, 0, fx(-3), 0, 5, 0, fx(7)));
    send_matrix({9{32'hAAAA_5555}});

    // Zero threshold: only exact zero is singular
    write_threshold(0);
    send_matrix('0);
    send_matrix(pack9(1, 0, 0, 0, 1, 0, 0, 0, 1));
    send_matrix(pack9(fx(1), 0, 0, 0, fx(1), 0, 0, 0, fx(1)));
    run_random(150);

    // Maximum threshold: nearly everything singular
    write_threshold({THW{1'b1}});
    send_matrix(pack9(32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF));
    run_random(150);

    // Mid thresholds with random traffic, including a calm stretch
    write_threshold(31'h0001_0000);
    calm = 1;
    run_random(300);
    calm = 0;
    write_threshold(THW'($urandom()));
    run_random(250);
    write_threshold(5);
    run_random(250);
    write_threshold(1);
    run_random(250);

    s_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
